[rtl/core/dpsq_pkg.sv]
// dpsq_pkg: shared constants, codes and controller/datapath handshake types
// for the dual policy service queue; no dependencies
`timescale 1ns / 1ps

package dpsq_pkg;

  localparam int CAPACITY = 64;

  localparam int MODE_W   = 2;
  localparam int VALUE_W  = 16;
  localparam int ID_W     = 32;
  localparam int STATUS_W = 2;

  localparam logic [MODE_W-1:0] MODE_ARRIVE  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_OLDEST  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_HIGHEST = 2'd2;
  localparam logic [MODE_W-1:0] MODE_NONE    = 2'd3;

  localparam logic [STATUS_W-1:0] ST_ACCEPTED = 2'd0;
  localparam logic [STATUS_W-1:0] ST_SERVED   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd3;

  typedef struct packed {
    logic arrive;
    logic reject_full;
    logic reject_empty;
    logic start_read;
    logic scan;
    logic move_init;
    logic move;
    logic finish_oldest;
    logic finish_highest;
    logic push;
  } dpsq_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic scan_done;
    logic move_done;
    logic out_free;
  } dpsq_status_t;

endpackage

[rtl/core/dpsq_in_if.sv]
// dpsq_in_if: request channel (valid, ready, mode, value)
// depends on dpsq_pkg for field widths
`timescale 1ns / 1ps

interface dpsq_in_if;
  logic                         valid;
  logic                         ready;
  logic [dpsq_pkg::MODE_W-1:0]  mode;
  logic [dpsq_pkg::VALUE_W-1:0] value;

  modport source (output valid, output mode, output value, input ready);
  modport sink   (input valid, input mode, input value, output ready);
endinterface

[rtl/core/dpsq_out_if.sv]
// dpsq_out_if: response channel (valid, ready, request_id, status)
// depends on dpsq_pkg for field widths
`timescale 1ns / 1ps

interface dpsq_out_if;
  logic                          valid;
  logic                          ready;
  logic [dpsq_pkg::ID_W-1:0]     request_id;
  logic [dpsq_pkg::STATUS_W-1:0] status;

  modport source (output valid, output request_id, output status, input ready);
  modport sink   (input valid, input request_id, input status, output ready);
endinterface

[rtl/core/dpsq_ram.sv]
// dpsq_ram: generic simple dual port ram, one write and one registered read
// no dependencies
`timescale 1ns / 1ps

module dpsq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/core/dpsq_ctrl.sv]
// dpsq_ctrl: sequencing state machine for arrive, oldest serve and highest serve
// depends on dpsq_pkg for codes and command/status types
`timescale 1ns / 1ps

module dpsq_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        req_valid,
  input  logic [dpsq_pkg::MODE_W-1:0] req_mode,
  output logic                        req_ready,
  input  dpsq_pkg::dpsq_status_t      st,
  output dpsq_pkg::dpsq_cmd_t         cmd
);

  typedef enum logic [6:0] {
    S_IDLE      = 7'b0000001,
    S_OLD_RD    = 7'b0000010,
    S_OLD_WAIT  = 7'b0000100,
    S_SCAN      = 7'b0001000,
    S_MOVE_INIT = 7'b0010000,
    S_MOVE      = 7'b0100000,
    S_DONE      = 7'b1000000
  } state_t;

  state_t state, state_next;

  assign req_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          case (req_mode)
            dpsq_pkg::MODE_ARRIVE: begin
              if (st.full) cmd.reject_full = 1'b1;
              else         cmd.arrive      = 1'b1;
              state_next = S_DONE;
            end
            dpsq_pkg::MODE_OLDEST: begin
              if (st.empty) begin
                cmd.reject_empty = 1'b1;
                state_next       = S_DONE;
              end else begin
                cmd.start_read = 1'b1;
                state_next     = S_OLD_RD;
              end
            end
            dpsq_pkg::MODE_HIGHEST: begin
              if (st.empty) begin
                cmd.reject_empty = 1'b1;
                state_next       = S_DONE;
              end else begin
                cmd.start_read = 1'b1;
                state_next     = S_SCAN;
              end
            end
            default: begin
              state_next = S_IDLE;
            end
          endcase
        end
      end
      S_OLD_RD: begin
        cmd.scan   = 1'b1;
        state_next = S_OLD_WAIT;
      end
      S_OLD_WAIT: begin
        cmd.finish_oldest = 1'b1;
        state_next        = S_DONE;
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (st.scan_done) state_next = S_MOVE_INIT;
      end
      S_MOVE_INIT: begin
        cmd.move_init = 1'b1;
        state_next    = S_MOVE;
      end
      S_MOVE: begin
        cmd.move = 1'b1;
        if (st.move_done) begin
          cmd.finish_highest = 1'b1;
          state_next         = S_DONE;
        end
      end
      S_DONE: begin
        if (st.out_free) begin
          cmd.push   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

endmodule

[rtl/core/dpsq_dp.sv]
// dpsq_dp: circular entry store, id counter, max scan, compaction and result regs
// depends on dpsq_pkg and dpsq_ram
`timescale 1ns / 1ps

module dpsq_dp #(
  parameter int CAPACITY = dpsq_pkg::CAPACITY
) (
  input  logic                          clk,
  input  logic                          rst,
  input  dpsq_pkg::dpsq_cmd_t           cmd,
  output dpsq_pkg::dpsq_status_t        st,
  input  logic [dpsq_pkg::VALUE_W-1:0]  req_value,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic [dpsq_pkg::ID_W-1:0]     out_id,
  output logic [dpsq_pkg::STATUS_W-1:0] out_status
);

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int WW = dpsq_pkg::VALUE_W + dpsq_pkg::ID_W;
  localparam logic [IW:0]   CAP_EXT = (IW + 1)'(CAPACITY);
  localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);

  function automatic logic [IW-1:0] phys(input logic [IW-1:0] base, input logic [IW-1:0] k);
    logic [IW:0] sum;
    sum = {1'b0, base} + {1'b0, k};
    if (sum >= CAP_EXT) sum = sum - CAP_EXT;
    return sum[IW-1:0];
  endfunction

  logic [IW-1:0]                 head;
  logic [CW-1:0]                 occ;
  logic [dpsq_pkg::ID_W-1:0]     nid;
  logic [CW-1:0]                 rd_k;
  logic [IW-1:0]                 rx_k;
  logic [IW-1:0]                 wr_k;
  logic                          rvalid;
  logic [dpsq_pkg::VALUE_W-1:0]  best_val;
  logic [dpsq_pkg::ID_W-1:0]     best_id;
  logic [IW-1:0]                 best_pos;
  logic [dpsq_pkg::ID_W-1:0]     res_id;
  logic [dpsq_pkg::STATUS_W-1:0] res_status;

  logic [dpsq_pkg::ID_W-1:0]    nid_inc;
  logic                         issue;
  logic                         reading;
  logic                         take;
  logic                         we;
  logic [IW-1:0]                waddr;
  logic [WW-1:0]                wdata;
  logic [IW-1:0]                raddr;
  logic [WW-1:0]                rdata;
  logic [dpsq_pkg::VALUE_W-1:0] rd_val;
  logic [dpsq_pkg::ID_W-1:0]    rd_id;

  assign nid_inc = (nid + 1'b1 == '0) ? dpsq_pkg::ID_W'(1) : nid + 1'b1;
  assign issue   = (rd_k < occ);
  assign reading = (cmd.scan || cmd.move) && issue;
  assign raddr   = phys(head, rd_k[IW-1:0]);
  assign rd_val  = rdata[WW-1 -: dpsq_pkg::VALUE_W];
  assign rd_id   = rdata[dpsq_pkg::ID_W-1:0];
  assign take    = cmd.scan && rvalid && ((rx_k == '0) || (rd_val > best_val));

  always_comb begin
    we    = 1'b0;
    waddr = phys(head, wr_k);
    wdata = rdata;
    if (cmd.arrive) begin
      we    = 1'b1;
      waddr = phys(head, occ[IW-1:0]);
      wdata = {req_value, nid_inc};
    end else if (cmd.move && rvalid) begin
      we = 1'b1;
    end
  end

  assign st.full      = (occ == CAP_CNT);
  assign st.empty     = (occ == '0);
  assign st.scan_done = rvalid && (CW'(rx_k) == occ - 1'b1);
  assign st.move_done = !issue && !rvalid;
  assign st.out_free  = !out_valid || out_ready;

  dpsq_ram #(
    .WIDTH (WW),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      head      <= '0;
      occ       <= '0;
      nid       <= '0;
      rvalid    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      rvalid <= reading;
      if (cmd.arrive) begin
        nid <= nid_inc;
        occ <= occ + 1'b1;
      end
      if (cmd.finish_oldest) begin
        head <= phys(head, IW'(1));
        occ  <= occ - 1'b1;
      end
      if (cmd.finish_highest) begin
        occ <= occ - 1'b1;
      end
      if (cmd.push)           out_valid <= 1'b1;
      else if (out_ready)     out_valid <= 1'b0;
    end
  end

  // indexes, scan tracking and payload
  always_ff @(posedge clk) begin
    if (cmd.start_read) begin
      rd_k <= '0;
    end else if (cmd.move_init) begin
      rd_k <= CW'(best_pos) + 1'b1;
    end else if (reading) begin
      rd_k <= rd_k + 1'b1;
    end
    if (reading) rx_k <= rd_k[IW-1:0];
    if (cmd.move_init) begin
      wr_k <= best_pos;
    end else if (cmd.move && rvalid) begin
      wr_k <= wr_k + 1'b1;
    end
    if (take) begin
      best_val <= rd_val;
      best_id  <= rd_id;
      best_pos <= rx_k;
    end
    if (cmd.arrive) begin
      res_id     <= nid_inc;
      res_status <= dpsq_pkg::ST_ACCEPTED;
    end else if (cmd.reject_full) begin
      res_id     <= '0;
      res_status <= dpsq_pkg::ST_FULL;
    end else if (cmd.reject_empty) begin
      res_id     <= '0;
      res_status <= dpsq_pkg::ST_EMPTY;
    end else if (cmd.finish_oldest) begin
      res_id     <= rd_id;
      res_status <= dpsq_pkg::ST_SERVED;
    end else if (cmd.finish_highest) begin
      res_id     <= best_id;
      res_status <= dpsq_pkg::ST_SERVED;
    end
    if (cmd.push) begin
      out_id     <= res_id;
      out_status <= res_status;
    end
  end

endmodule

[rtl/core/dual_policy_service_queue.sv]
// dual_policy_service_queue: request store served oldest first or highest value first
// depends on dpsq_pkg, dpsq_in_if, dpsq_out_if, dpsq_ctrl, dpsq_dp
//
// req carries mode and value: arrive (0), serve oldest (1), serve highest value (2).
// mode 3 is taken and dropped with no response. every other word gives one rsp
// word: request_id and status (accepted, served, empty on serve, full on arrive).
// entries live in a circular buffer in one ram with a registered read port.
// arrive writes one ram entry and error status words touch no ram; serve
// oldest reads the ram once at the head; serve highest runs a max scan over
// the ram (one entry a cycle) and then compacts the entries behind the
// winner (one entry moved a cycle through the same ram).
// one word is in work at a time; req.ready is high only when the sequencer is
// idle, so the next word is accepted the cycle after the result is pushed to rsp.
// rsp is an output register: a stalled receiver holds the word, and the next
// request may still be accepted and processed while it waits.
// reset (rst, synchronous) empties the store and restarts ids at 1; no
// clearing pass is needed.
`timescale 1ns / 1ps

module dual_policy_service_queue #(
  parameter int CAPACITY = dpsq_pkg::CAPACITY
) (
  input logic         clk,
  input logic         rst,
  dpsq_in_if.sink     req,
  dpsq_out_if.source  rsp
);

  dpsq_pkg::dpsq_cmd_t    cmd;
  dpsq_pkg::dpsq_status_t st;

  dpsq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_mode  (req.mode),
    .req_ready (req.ready),
    .st        (st),
    .cmd       (cmd)
  );

  dpsq_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .st         (st),
    .req_value  (req.value),
    .out_ready  (rsp.ready),
    .out_valid  (rsp.valid),
    .out_id     (rsp.request_id),
    .out_status (rsp.status)
  );

  a_err_id_zero: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && (rsp.status == dpsq_pkg::ST_EMPTY || rsp.status == dpsq_pkg::ST_FULL)
    |-> rsp.request_id == '0)
    else $error("error status with nonzero id");

  a_ok_id_nonzero: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && (rsp.status == dpsq_pkg::ST_ACCEPTED || rsp.status == dpsq_pkg::ST_SERVED)
    |-> rsp.request_id != '0)
    else $error("good status with id zero");

  a_busy_not_ready: assert property (@(posedge clk) disable iff (rst)
    (cmd.scan || cmd.move || cmd.push) |-> !req.ready)
    else $error("request accepted while busy");

  a_full_blocks_write: assert property (@(posedge clk) disable iff (rst)
    st.full |-> !cmd.arrive)
    else $error("arrival written into full store");

endmodule

[test/tb_dual_policy_service_queue.sv]
// tb_dual_policy_service_queue: self-checking testbench for the dual policy service queue
// drives dpsq_in_if, checks dpsq_out_if against an in-bench store model
// depends on dpsq_pkg, dpsq_in_if, dpsq_out_if and dual_policy_service_queue
`timescale 1ns / 1ps

module tb_dual_policy_service_queue;

  typedef struct packed {
    logic [dpsq_pkg::ID_W-1:0]     request_id;
    logic [dpsq_pkg::STATUS_W-1:0] status;
  } outcome_t;

  logic clk;
  logic rst;

  dpsq_in_if  req_ch ();
  dpsq_out_if rsp_ch ();

  dual_policy_service_queue dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  // store model
  logic [dpsq_pkg::VALUE_W-1:0] held_value[$];
  logic [dpsq_pkg::ID_W-1:0]    held_id[$];
  logic [dpsq_pkg::ID_W-1:0]    last_id;

  outcome_t awaited[$];
  outcome_t head_result;

  int mismatches;
  int recv_hold;
  bit send_idle_on;
  bit recv_idle_on;

  int arrivals;
  int served_oldest;
  int served_highest;
  int empty_rejects;
  int full_rejects;
  int dropped_words;

  always #5 clk = ~clk;

  function automatic bit predict_service(input logic [dpsq_pkg::MODE_W-1:0] mode,
                                         input logic [dpsq_pkg::VALUE_W-1:0] value,
                                         output outcome_t res);
    int pos;
    res.request_id = '0;
    res.status     = dpsq_pkg::ST_EMPTY;
    if (mode == dpsq_pkg::MODE_NONE) return 1'b0;
    if (mode == dpsq_pkg::MODE_ARRIVE) begin
      if (held_id.size() >= dpsq_pkg::CAPACITY) begin
        res.status = dpsq_pkg::ST_FULL;
        return 1'b1;
      end
      last_id = last_id + 1;
      if (last_id == '0) last_id = 1;
      held_value = {held_value, value};
      held_id    = {held_id, last_id};
      res.request_id = last_id;
      res.status     = dpsq_pkg::ST_ACCEPTED;
      return 1'b1;
    end
    if (held_id.size() == 0) return 1'b1;
    pos = 0;
    if (mode == dpsq_pkg::MODE_HIGHEST) begin
      for (int i = 1; i < held_id.size(); i++) begin
        if (held_value[i] > held_value[pos]) pos = i;
      end
    end
    res.request_id = held_id[pos];
    res.status     = dpsq_pkg::ST_SERVED;
    held_value.delete(pos);
    held_id.delete(pos);
    return 1'b1;
  endfunction

  task automatic send_word(input logic [dpsq_pkg::MODE_W-1:0] mode,
                           input logic [dpsq_pkg::VALUE_W-1:0] value);
    int gap;
    outcome_t res;
    gap = send_idle_on ? $urandom_range(0, 9) : 0;
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.mode  <= mode;
    req_ch.value <= value;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    if (predict_service(mode, value, res)) begin
      awaited = {awaited, res};
      case (res.status)
        dpsq_pkg::ST_ACCEPTED: arrivals++;
        dpsq_pkg::ST_SERVED: begin
          if (mode == dpsq_pkg::MODE_OLDEST) served_oldest++;
          else served_highest++;
        end
        dpsq_pkg::ST_EMPTY: empty_rejects++;
        default: full_rejects++;
      endcase
    end else begin
      dropped_words++;
    end
    @(negedge clk);
  endtask

  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    do @(negedge clk); while (awaited.size() != 0);
  endtask

  function automatic logic [dpsq_pkg::VALUE_W-1:0] draw_value(input int style);
    case (style)
      0: return dpsq_pkg::VALUE_W'($urandom_range(0, 65535));
      1: return dpsq_pkg::VALUE_W'($urandom_range(0, 3));
      default: begin
        case ($urandom_range(0, 3))
          0: return 16'h0000;
          1: return 16'hFFFF;
          2: return 16'h8000;
          default: return 16'h7FFF;
        endcase
      end
    endcase
  endfunction

  function automatic logic [dpsq_pkg::MODE_W-1:0] draw_serve();
    return ($urandom_range(0, 1) == 0) ? dpsq_pkg::MODE_OLDEST : dpsq_pkg::MODE_HIGHEST;
  endfunction

  // response checker
  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      recv_hold = recv_idle_on ? $urandom_range(0, 9) : 0;
      if (awaited.size() == 0) begin
        $display("%0t: unexpected word, expected none, actual id %0d status %0d",
                 $time, rsp_ch.request_id, rsp_ch.status);
        mismatches++;
      end else begin
        head_result = awaited.pop_front();
        if (rsp_ch.request_id !== head_result.request_id) begin
          $display("%0t: request_id mismatch, expected %0d, actual %0d",
                   $time, head_result.request_id, rsp_ch.request_id);
          mismatches++;
        end
        if (rsp_ch.status !== head_result.status) begin
          $display("%0t: status mismatch, expected %0d, actual %0d",
                   $time, head_result.status, rsp_ch.status);
          mismatches++;
        end
      end
    end
  end

  // receiver stalls
  always @(negedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else if (recv_hold > 0) begin
      rsp_ch.ready <= 1'b0;
      recv_hold--;
    end else begin
      rsp_ch.ready <= 1'b1;
    end
  end

  task automatic test_empty_store();
    send_word(dpsq_pkg::MODE_OLDEST, 16'hFFFF);
    send_word(dpsq_pkg::MODE_HIGHEST, 16'h0000);
    send_word(dpsq_pkg::MODE_NONE, 16'hFFFF);
    send_word(dpsq_pkg::MODE_NONE, 16'h0000);
  endtask

  task automatic test_policies_and_ties();
    send_word(dpsq_pkg::MODE_ARRIVE, 16'h0000);
    send_word(dpsq_pkg::MODE_ARRIVE, 16'hFFFF);
    send_word(dpsq_pkg::MODE_ARRIVE, 16'h8000);
    send_word(dpsq_pkg::MODE_ARRIVE, 16'hFFFF);
    send_word(dpsq_pkg::MODE_ARRIVE, 16'h0001);
    send_word(dpsq_pkg::MODE_ARRIVE, 16'h5555);
    send_word(dpsq_pkg::MODE_HIGHEST, 16'h0000);
    send_word(dpsq_pkg::MODE_HIGHEST, 16'hAAAA);
    send_word(dpsq_pkg::MODE_OLDEST, 16'hFFFF);
    send_word(dpsq_pkg::MODE_NONE, 16'hAAAA);
    send_word(dpsq_pkg::MODE_HIGHEST, 16'h0000);
    send_word(dpsq_pkg::MODE_ARRIVE, 16'h5555);
    send_word(dpsq_pkg::MODE_HIGHEST, 16'h0000);
    send_word(dpsq_pkg::MODE_OLDEST, 16'h0000);
    send_word(dpsq_pkg::MODE_OLDEST, 16'h0000);
    send_word(dpsq_pkg::MODE_OLDEST, 16'h0000);
    wait_drained();
  endtask

  task automatic test_fill_to_full();
    int style;
    style = $urandom_range(0, 2);
    while (held_id.size() < dpsq_pkg::CAPACITY) begin
      send_word(dpsq_pkg::MODE_ARRIVE, draw_value(style));
    end
    send_word(dpsq_pkg::MODE_ARRIVE, draw_value(0));
    send_word(dpsq_pkg::MODE_ARRIVE, draw_value(0));
    send_idle_on = 1'b0;
    recv_idle_on = 1'b1;
    while (held_id.size() > 0) send_word(draw_serve(), draw_value(0));
    send_word(draw_serve(), draw_value(0));
    send_idle_on = 1'b1;
    repeat (dpsq_pkg::CAPACITY / 2) send_word(dpsq_pkg::MODE_ARRIVE, draw_value(1));
    wait_drained();
  endtask

  task automatic test_random_traffic(input int n_words);
    int sent;
    int span;
    int arrive_pct;
    int style;
    int pick;
    sent = 0;
    while (sent < n_words) begin
      span         = $urandom_range(30, 80);
      arrive_pct   = $urandom_range(20, 80);
      style        = $urandom_range(0, 2);
      send_idle_on = $urandom_range(0, 3) != 0;
      recv_idle_on = $urandom_range(0, 3) != 0;
      repeat (span) begin
        pick = $urandom_range(0, 99);
        if (pick < 3) send_word(dpsq_pkg::MODE_NONE, draw_value(0));
        else if (pick < 3 + arrive_pct) send_word(dpsq_pkg::MODE_ARRIVE, draw_value(style));
        else send_word(draw_serve(), draw_value(0));
        sent++;
      end
      if ($urandom_range(0, 9) == 0) wait_drained();
    end
  endtask

  initial begin
    clk          = 1'b0;
    rst          = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.mode  = dpsq_pkg::MODE_ARRIVE;
    req_ch.value = '0;
    rsp_ch.ready = 1'b0;
    last_id      = '0;
    mismatches   = 0;
    recv_hold    = 0;
    send_idle_on = 1'b1;
    recv_idle_on = 1'b1;
    repeat (9) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_empty_store();
    test_policies_and_ties();
    test_fill_to_full();
    test_random_traffic(620);

    wait_drained();
    repeat (2 * dpsq_pkg::CAPACITY + 20) @(negedge clk);
    $display("covered %0d arrivals, %0d oldest and %0d highest serves,",
             arrivals, served_oldest, served_highest);
    $display("%0d empty and %0d full rejects, %0d unused-mode words",
             empty_rejects, full_rejects, dropped_words);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #8_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
